// File: rtl/core/pppc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pppc_pkg: shared types and constants of the pixel plot cache
// register codes, configuration record and the emit command bundle
// ----------------------------------------------------------------------------
package pppc_pkg;

  localparam int unsigned SegW = 13;  // {y, x[7:3]}
  localparam int unsigned OffW = 19;

  typedef enum logic [2:0] {
    CFG_TRANSPARENT = 3'd0,
    CFG_DITHER      = 3'd1,
    CFG_FREEZE      = 3'd2,
    CFG_OBJECT      = 3'd3,
    CFG_MODE        = 3'd4,
    CFG_HEIGHT      = 3'd5,
    CFG_BASE        = 3'd6
  } cfg_idx_e;

  // request kinds
  localparam logic KIND_PLOT  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  localparam logic [1:0] MODE_2BPP  = 2'd0;
  localparam logic [1:0] MODE_8BPP  = 2'd3;
  localparam logic [1:0] LAYOUT_128 = 2'd0;
  localparam logic [1:0] LAYOUT_160 = 2'd1;
  localparam logic [1:0] LAYOUT_192 = 2'd2;
  localparam logic [1:0] LAYOUT_OBJ = 2'd3;

  localparam logic [7:0] FULL_MASK = 8'hff;

  typedef struct packed {
    logic       transparent_enable;
    logic       dither_enable;
    logic       freeze_high;
    logic       object_layout;
    logic [1:0] screen_mode;
    logic [1:0] screen_height;
    logic [7:0] screen_base;
  } cfg_t;

  typedef struct packed {
    logic start;     // latch entry and begin emitting
    logic is_final;  // its last byte ends the request
  } emit_cmd_t;

endpackage

// File: rtl/core/pppc_plane_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pppc_plane_unit: bitplane byte emitter
// turns one cached row segment into 2, 4 or 8 masked plane writes; unless the output stalls, one a cycle
// ----------------------------------------------------------------------------
module pppc_plane_unit import pppc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  emit_cmd_t            cmd_i,
  input  logic [7:0][7:0]      pixels_i,
  input  logic [7:0]           pend_i,
  input  logic [SegW-1:0]      seg_i,
  input  cfg_t                 cfg_i,
  output logic                 busy_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [OffW-1:0]      out_ram_offset_o,
  output logic [7:0]           out_byte_data_o,
  output logic [7:0]           out_bit_mask_o,
  output logic                 out_last_o
);

  typedef enum logic [1:0] {U_IDLE, U_ADDR, U_EMIT} state_e;

  state_e          state_q;
  logic [7:0][7:0] pix_q;
  logic [7:0]      pend_q;
  logic [SegW-1:0] seg_q;
  logic            final_q;
  logic [OffW-1:0] addr_q;
  logic [2:0]      n_q;
  logic            out_valid_q;
  logic [OffW-1:0] out_off_q;
  logic [7:0]      out_data_q;
  logic [7:0]      out_mask_q;
  logic            out_last_q;

  logic [1:0]      layout;
  logic [9:0]      cn;
  logic [OffW-1:0] cn_sh;
  logic [OffW-1:0] addr_d;
  logic [2:0]      n_last;
  logic [OffW-1:0] plane_off;
  logic [7:0]      plane_bits;
  logic            load;

  // tile number of the segment
  always_comb begin
    layout = cfg_i.object_layout ? LAYOUT_OBJ : cfg_i.screen_height;
    unique case (layout)
      LAYOUT_128: cn = {1'b0, seg_q[4:0], 4'b0} + {5'b0, seg_q[12:8]};
      LAYOUT_160: cn = {1'b0, seg_q[4:0], 4'b0} + {3'b0, seg_q[4:0], 2'b0}
                     + {5'b0, seg_q[12:8]};
      LAYOUT_192: cn = {1'b0, seg_q[4:0], 4'b0} + {2'b0, seg_q[4:0], 3'b0}
                     + {5'b0, seg_q[12:8]};
      default:    cn = {seg_q[12], seg_q[4], seg_q[11:8], seg_q[3:0]};
    endcase
  end

  always_comb begin
    unique case (cfg_i.screen_mode)
      MODE_2BPP: begin
        n_last = 3'd1;
        cn_sh  = {9'b0, cn} << 4;
      end
      MODE_8BPP: begin
        n_last = 3'd7;
        cn_sh  = {9'b0, cn} << 6;
      end
      default: begin
        n_last = 3'd3;
        cn_sh  = {9'b0, cn} << 5;
      end
    endcase
    addr_d    = cn_sh + {1'b0, cfg_i.screen_base, 10'b0} + {15'b0, seg_q[7:5], 1'b0};
    plane_off = {13'b0, n_q[2:1], 3'b0, n_q[0]};
    for (int p = 0; p < 8; p++) begin
      plane_bits[p] = pix_q[p][n_q];
    end
    load = (state_q == U_EMIT) && (!out_valid_q || !out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= U_IDLE;
      pix_q       <= '0;
      pend_q      <= '0;
      seg_q       <= '0;
      final_q     <= 1'b0;
      addr_q      <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
      out_off_q   <= '0;
      out_data_q  <= '0;
      out_mask_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (!out_stall_i && !load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        U_IDLE: begin
          if (cmd_i.start) begin
            pix_q   <= pixels_i;
            pend_q  <= pend_i;
            seg_q   <= seg_i;
            final_q <= cmd_i.is_final;
            n_q     <= '0;
            if (pend_i != 8'h00) begin
              state_q <= U_ADDR;
            end
          end
        end
        U_ADDR: begin
          addr_q  <= addr_d;
          state_q <= U_EMIT;
        end
        U_EMIT: begin
          if (load) begin
            out_valid_q <= 1'b1;
            out_off_q   <= addr_q + plane_off;
            out_data_q  <= plane_bits & pend_q;
            out_mask_q  <= pend_q;
            out_last_q  <= final_q && (n_q == n_last);
            n_q         <= n_q + 3'd1;
            if (n_q == n_last) begin
              state_q <= U_IDLE;
            end
          end
        end
        default: state_q <= U_IDLE;
      endcase
    end
  end

  assign busy_o           = (state_q != U_IDLE);
  assign out_valid_o      = out_valid_q;
  assign out_ram_offset_o = out_off_q;
  assign out_byte_data_o  = out_data_q;
  assign out_bit_mask_o   = out_mask_q;
  assign out_last_o       = out_last_q;

  a_work_has_pixels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != U_IDLE) |-> (pend_q != 8'h00))
    else $error("plane unit working on an empty entry");

  a_start_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> (state_q == U_IDLE))
    else $error("emit started while plane unit busy");

endmodule

// File: rtl/core/planar_pixel_plot_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_pixel_plot_cache: pixel plotter with a two-entry row segment cache
// stores chunky pixels per 8-pixel segment and writes them out as bitplanes
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+----------------------------------
//  in      | input     | in_valid_i / in_stall_o | kind, x_coord, y_coord, color
//  out     | output    | out_valid_o/out_stall_i | ram_offset, byte_data, bit_mask, last
//  cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
//  a plot that hits the front segment and does not fill it is taken without a stall
//  an entry write-out covers 2, 4 or 8 planes: the plane unit latches the entry,
//  forms its address, then emits one masked byte per cycle unless the output
//  stalls; a flush writes out the back entry, then the front entry
//  the input stalls while a request is being worked on, the output register
//  lets the last byte wait while the next request is taken
//  reset empties both entries; pixel storage itself is not cleared
// ----------------------------------------------------------------------------
module planar_pixel_plot_cache import pppc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  // configuration writes
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_index_i,
  input  logic [7:0]      cfg_data_i,
  // request channel
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            in_kind_i,
  input  logic [7:0]      in_x_coord_i,
  input  logic [7:0]      in_y_coord_i,
  input  logic [7:0]      in_color_i,
  // ram write channel
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [OffW-1:0] out_ram_offset_o,
  output logic [7:0]      out_byte_data_o,
  output logic [7:0]      out_bit_mask_o,
  output logic            out_last_o
);

  typedef enum logic [1:0] {T_IDLE, T_FLUSH_FRONT, T_DRAIN} state_e;

  state_e          state_q, state_d;
  cfg_t            cfg_q;

  // front entry (0) and back entry (1)
  logic            front_valid_q, front_valid_d;
  logic [7:0]      front_pend_q, front_pend_d;
  logic [7:0]      back_pend_q, back_pend_d;
  logic [SegW-1:0] front_seg_q, front_seg_d;
  logic [SegW-1:0] back_seg_q, back_seg_d;
  logic [7:0][7:0] front_pix_q;
  logic [7:0][7:0] back_pix_q, back_pix_d;
  logic            pix_wr;
  logic            back_wr;

  logic            accept;
  logic            md8;
  logic            skip;
  logic [7:0]      col;
  logic [SegW-1:0] seg_in;
  logic [2:0]      pix_idx;
  logic [7:0]      pix_bit;
  logic            hit;
  logic [7:0]      new_pend;
  logic [7:0][7:0] front_pix_new;

  // emit path
  emit_cmd_t       cmd;
  logic            sel_front;
  logic            unit_busy;

  assign in_stall_o = (state_q != T_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // plot decode: transparency, dither, segment and pixel slot
  always_comb begin
    md8  = (cfg_q.screen_mode == MODE_8BPP);
    skip = 1'b0;
    if (!cfg_q.transparent_enable) begin
      if (md8 && !cfg_q.freeze_high) begin
        skip = (in_color_i == 8'h00);
      end else begin
        skip = (in_color_i[3:0] == 4'h0);
      end
    end
    col = in_color_i;
    if (cfg_q.dither_enable && !md8) begin
      // checkerboard picks high nibble on odd parity
      col = (in_x_coord_i[0] ^ in_y_coord_i[0]) ? {4'h0, in_color_i[7:4]}
                                                : {4'h0, in_color_i[3:0]};
    end
    seg_in   = {in_y_coord_i, in_x_coord_i[7:3]};
    pix_idx  = ~in_x_coord_i[2:0];
    pix_bit  = 8'h01 << pix_idx;
    hit      = front_valid_q && (seg_in == front_seg_q);
    new_pend = front_pend_q | pix_bit;
    front_pix_new          = front_pix_q;
    front_pix_new[pix_idx] = col;
  end

  // request sequencer
  always_comb begin
    state_d       = state_q;
    front_valid_d = front_valid_q;
    front_pend_d  = front_pend_q;
    back_pend_d   = back_pend_q;
    front_seg_d   = front_seg_q;
    back_seg_d    = back_seg_q;
    back_pix_d    = back_pix_q;
    back_wr       = 1'b0;
    pix_wr        = 1'b0;
    cmd           = '0;
    sel_front     = 1'b0;
    unique case (state_q)
      T_IDLE: begin
        if (accept) begin
          if (in_kind_i == KIND_FLUSH) begin
            // flush: back entry first, front entry next
            cmd.start    = 1'b1;
            cmd.is_final = (front_pend_q == 8'h00);
            back_pend_d  = 8'h00;
            state_d      = T_FLUSH_FRONT;
          end else if (!skip) begin
            pix_wr = 1'b1;
            if (!hit) begin
              // new segment: write out back, front moves back, start fresh
              cmd.start     = 1'b1;
              cmd.is_final  = 1'b1;
              back_wr       = 1'b1;
              back_pix_d    = front_pix_q;
              back_seg_d    = front_seg_q;
              back_pend_d   = front_pend_q;
              front_seg_d   = seg_in;
              front_valid_d = 1'b1;
              front_pend_d  = pix_bit;
              state_d       = T_DRAIN;
            end else if (new_pend == FULL_MASK) begin
              // full front: write out back, full front moves back
              cmd.start    = 1'b1;
              cmd.is_final = 1'b1;
              back_wr      = 1'b1;
              back_pix_d   = front_pix_new;
              back_seg_d   = front_seg_q;
              back_pend_d  = FULL_MASK;
              front_pend_d = 8'h00;
              state_d      = T_DRAIN;
            end else begin
              front_pend_d = new_pend;
            end
          end
        end
      end
      T_FLUSH_FRONT: begin
        if (!unit_busy) begin
          cmd.start    = 1'b1;
          cmd.is_final = 1'b1;
          sel_front    = 1'b1;
          front_pend_d = 8'h00;
          state_d      = T_DRAIN;
        end
      end
      T_DRAIN: begin
        if (!unit_busy) begin
          state_d = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= T_IDLE;
      cfg_q         <= '0;
      front_valid_q <= 1'b0;
      front_pend_q  <= 8'h00;
      back_pend_q   <= 8'h00;
    end else begin
      state_q       <= state_d;
      front_valid_q <= front_valid_d;
      front_pend_q  <= front_pend_d;
      back_pend_q   <= back_pend_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_TRANSPARENT: cfg_q.transparent_enable <= cfg_data_i[0];
          CFG_DITHER:      cfg_q.dither_enable      <= cfg_data_i[0];
          CFG_FREEZE:      cfg_q.freeze_high        <= cfg_data_i[0];
          CFG_OBJECT:      cfg_q.object_layout      <= cfg_data_i[0];
          CFG_MODE:        cfg_q.screen_mode        <= cfg_data_i[1:0];
          CFG_HEIGHT:      cfg_q.screen_height      <= cfg_data_i[1:0];
          CFG_BASE:        cfg_q.screen_base        <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // segment numbers and pixels only matter while pending bits are set
  always_ff @(posedge clk_i) begin
    front_seg_q <= front_seg_d;
    back_seg_q  <= back_seg_d;
    if (pix_wr) begin
      front_pix_q[pix_idx] <= col;
    end
    if (back_wr) begin
      back_pix_q <= back_pix_d;
    end
  end

  pppc_plane_unit u_plane (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .pixels_i         (sel_front ? front_pix_q : back_pix_q),
    .pend_i           (sel_front ? front_pend_q : back_pend_q),
    .seg_i            (sel_front ? front_seg_q : back_seg_q),
    .cfg_i            (cfg_q),
    .busy_o           (unit_busy),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_ram_offset_o (out_ram_offset_o),
    .out_byte_data_o  (out_byte_data_o),
    .out_bit_mask_o   (out_bit_mask_o),
    .out_last_o       (out_last_o)
  );

  a_idle_unit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_IDLE) |-> !unit_busy)
    else $error("request accepted while plane unit still busy");

  a_front_never_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_IDLE) |-> (front_pend_q != FULL_MASK))
    else $error("full front entry left in cache");

  a_pend_has_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (front_pend_q != 8'h00) |-> front_valid_q)
    else $error("front pixels pending without a segment");

  a_flush_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_kind_i == KIND_FLUSH)) |=> (state_q == T_FLUSH_FRONT))
    else $error("flush did not go on to the front entry");

endmodule
